FILE: rtl/ffha_pkg.sv
// Shared types and constants for the first-fit heap allocator.
package ffha_pkg;

   localparam int MAX_BLOCKS    = 64;
   localparam int IDX_W         = $clog2(MAX_BLOCKS);
   localparam int CNT_W         = $clog2(MAX_BLOCKS + 1);
   localparam int OFF_W         = 20;
   localparam int HEAP_W        = 21;
   localparam int HEADER_BYTES  = 24;
   localparam int CONTROL_BYTES = 8;
   localparam int MIN_SPLIT     = 8;
   localparam int HEAP_LIMIT    = 1048576;
   localparam int HEAP_RESET    = 65536;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_NO_SPACE    = 2'd1,
      ST_DOUBLE_FREE = 2'd2,
      ST_NOT_START   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      WS_INIT,
      WS_COPY,
      WS_TAKE_ALL,
      WS_TAKE_PART,
      WS_REMAIN,
      WS_MERGE_SELF,
      WS_MERGE_LEFT
   } wr_sel_type;

   typedef struct packed {
      logic             free;
      logic [OFF_W-1:0] size;
      logic [OFF_W-1:0] start;
   } entry_type;

   typedef struct packed {
      logic             capture;
      logic             clr_right;
      logic             lat_hit;
      logic             lat_prev;
      logic             lat_next;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      wr_sel_type       wr_sel;
      logic             rsp_load;
      status_type       rsp_status;
      logic             rsp_grant;
   } cmd_type;

   typedef struct packed {
      logic kind;
      logic fit;
      logic big;
      logic match;
      logic hit_free;
      logic prev_free;
      logic right_free;
      logic rsp_busy;
   } sts_type;

endpackage

FILE: rtl/first_fit_heap_allocator_top.sv
// Top level of the first-fit heap allocator.
//
// Request channel (req_*): one beat is one operation. req_kind 0 allocates
// req_request_bytes (rounded up to 8); req_kind 1 releases the payload at
// req_release_offset. Response channel (rsp_*): exactly one beat per request,
// in order, with rsp_status and rsp_payload_offset (zero unless an
// allocation was granted).
// csr_wr_en/csr_wr_data write the heap size; the block table is rebuilt as
// one free block. Write only while no request is in flight.
// One request is worked at a time by a table walk over a single-port read /
// single-port write memory. A request scans up to the block count, then a
// split shifts the tail up one entry, or a release shifts it down by up to
// two; scan plus shift together touch each entry at most once. The next
// request is taken in the cycle after the response is loaded.
// Reset (synchronous) restores a 65536-byte heap and writes the initial
// entry in S_INIT before req_ready rises.
// If rsp_ready is held low, the finished response waits in its output
// register; the next request is still taken, and its response waits until
// the previous beat leaves.
module first_fit_heap_allocator_top import ffha_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [HEAP_W-1:0] csr_wr_data,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_kind,
   input  logic [OFF_W-1:0]  req_request_bytes,
   input  logic [OFF_W-1:0]  req_release_offset,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_status,
   output logic [OFF_W-1:0]  rsp_payload_offset
);

   cmd_type cmd;
   sts_type sts;

   ffha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ffha_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_kind           (req_kind),
      .req_request_bytes  (req_request_bytes),
      .req_release_offset (req_release_offset),
      .cmd                (cmd),
      .sts                (sts),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_payload_offset (rsp_payload_offset)
   );

endmodule

FILE: rtl/ffha_dpath.sv
// Datapath: block table memory, request registers, entry arithmetic, result register.
module ffha_dpath import ffha_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [HEAP_W-1:0] csr_wr_data,
   input  logic              req_kind,
   input  logic [OFF_W-1:0]  req_request_bytes,
   input  logic [OFF_W-1:0]  req_release_offset,
   input  cmd_type           cmd,
   output sts_type           sts,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_status,
   output logic [OFF_W-1:0]  rsp_payload_offset
);

   entry_type mem [MAX_BLOCKS];
   entry_type rd_q_ff;

   logic [HEAP_W-1:0] heap_ff;
   logic              kind_ff;
   logic [HEAP_W-1:0] need_ff;
   logic [OFF_W-1:0]  off_ff;
   entry_type         hit_ff;
   entry_type         prev_ff;
   logic [OFF_W-1:0]  next_size_ff;
   logic              right_ff;
   logic              rsp_valid_ff;
   status_type        rsp_status_ff;
   logic [OFF_W-1:0]  rsp_offset_ff;

   logic [HEAP_W-1:0] heap_clamp;
   logic [HEAP_W-1:0] size0;
   logic [HEAP_W-1:0] need_in;
   logic [OFF_W-1:0]  self_size;
   entry_type         wr_data;

   assign heap_clamp = (heap_ff > HEAP_W'(HEAP_LIMIT)) ? HEAP_W'(HEAP_LIMIT) : heap_ff;
   assign size0 = (heap_clamp >= HEAP_W'(CONTROL_BYTES + HEADER_BYTES))
                ? heap_clamp - HEAP_W'(CONTROL_BYTES + HEADER_BYTES) : '0;
   assign need_in = ({1'b0, req_request_bytes} + HEAP_W'(7)) & ~HEAP_W'(7);
   assign self_size = hit_ff.size
                    + (right_ff ? OFF_W'(HEADER_BYTES) + next_size_ff : '0);

   always_comb begin
      wr_data = rd_q_ff;
      case (cmd.wr_sel)
         WS_INIT: begin
            wr_data.start = OFF_W'(CONTROL_BYTES);
            wr_data.size  = size0[OFF_W-1:0];
            wr_data.free  = 1'b1;
         end
         WS_COPY: wr_data = rd_q_ff;
         WS_TAKE_ALL: begin
            wr_data      = hit_ff;
            wr_data.free = 1'b0;
         end
         WS_TAKE_PART: begin
            wr_data      = hit_ff;
            wr_data.size = need_ff[OFF_W-1:0];
            wr_data.free = 1'b0;
         end
         WS_REMAIN: begin
            wr_data.start = hit_ff.start + OFF_W'(HEADER_BYTES) + need_ff[OFF_W-1:0];
            wr_data.size  = hit_ff.size - need_ff[OFF_W-1:0] - OFF_W'(HEADER_BYTES);
            wr_data.free  = 1'b1;
         end
         WS_MERGE_SELF: begin
            wr_data      = hit_ff;
            wr_data.size = self_size;
            wr_data.free = 1'b1;
         end
         WS_MERGE_LEFT: begin
            wr_data      = prev_ff;
            wr_data.size = prev_ff.size + OFF_W'(HEADER_BYTES) + self_size;
            wr_data.free = 1'b1;
         end
         default: wr_data = rd_q_ff;
      endcase
   end

   // block table: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_q_ff <= mem[cmd.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_kind;
         need_ff <= need_in;
         off_ff  <= req_release_offset;
      end
      if (cmd.lat_hit) begin
         hit_ff <= rd_q_ff;
      end
      if (cmd.lat_prev) begin
         prev_ff <= rd_q_ff;
      end
      if (cmd.lat_next) begin
         next_size_ff <= rd_q_ff.size;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= cmd.rsp_status;
         rsp_offset_ff <= cmd.rsp_grant ? hit_ff.start + OFF_W'(HEADER_BYTES) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_ff      <= HEAP_W'(HEAP_RESET);
         right_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            heap_ff <= csr_wr_data;
         end
         if (cmd.clr_right) begin
            right_ff <= 1'b0;
         end else if (cmd.lat_next) begin
            right_ff <= rd_q_ff.free;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign sts.kind       = kind_ff;
   assign sts.fit        = rd_q_ff.free && ({1'b0, rd_q_ff.size} >= need_ff);
   assign sts.big        = {2'b0, rd_q_ff.size} >= ({1'b0, need_ff}
                           + (HEAP_W+1)'(HEADER_BYTES + MIN_SPLIT));
   assign sts.match      = ({1'b0, rd_q_ff.start} + HEAP_W'(HEADER_BYTES)) == {1'b0, off_ff};
   assign sts.hit_free   = rd_q_ff.free;
   assign sts.prev_free  = prev_ff.free;
   assign sts.right_free = right_ff;
   assign sts.rsp_busy   = rsp_valid_ff && !rsp_ready;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_payload_offset = rsp_offset_ff;

endmodule

FILE: rtl/ffha_ctrl.sv
// Controller: sequences table scan, entry shifts, merge and result handoff.
module ffha_ctrl import ffha_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    csr_wr_en,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_UP_RD, S_UP_WR, S_REM_WR,
      S_TAKE_WR, S_NX_RD, S_NX_CHK, S_MERGE, S_DN_RD, S_DN_WR, S_RESULT
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic [1:0]       d_ff, d_in;
   logic             sp_ff, sp_in;
   status_type       res_ff, res_in;
   logic             grant_ff, grant_in;

   logic [CNT_W-1:0] i_next;
   logic [CNT_W-1:0] k_far;
   logic             left;

   assign i_next = i_ff + CNT_W'(1);
   assign k_far  = k_ff + CNT_W'(d_ff);
   assign left   = (i_ff != '0) && sts.prev_free;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      i_in      = i_ff;
      k_in      = k_ff;
      d_in      = d_ff;
      sp_in     = sp_ff;
      res_in    = res_ff;
      grant_in  = grant_ff;
      cmd       = '0;
      cmd.wr_sel     = WS_COPY;
      cmd.rsp_status = res_ff;
      cmd.rsp_grant  = grant_ff;
      req_ready = 1'b0;

      unique case (state_ff)
         S_INIT: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = '0;
            cmd.wr_sel  = WS_INIT;
            cnt_in      = CNT_W'(1);
            state_in    = S_IDLE;
         end
         S_IDLE: begin
            req_ready = !csr_wr_en;
            if (req_valid && !csr_wr_en) begin
               cmd.capture   = 1'b1;
               cmd.clr_right = 1'b1;
               i_in          = '0;
               state_in      = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            if (i_ff == cnt_ff) begin
               res_in   = sts.kind ? ST_NOT_START : ST_NO_SPACE;
               grant_in = 1'b0;
               state_in = S_RESULT;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = i_ff[IDX_W-1:0];
               state_in    = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            if (!sts.kind) begin
               if (sts.fit) begin
                  cmd.lat_hit = 1'b1;
                  sp_in       = sts.big && (cnt_ff < CNT_W'(MAX_BLOCKS));
                  k_in        = cnt_ff;
                  state_in    = (sts.big && (cnt_ff < CNT_W'(MAX_BLOCKS)))
                              ? S_UP_RD : S_TAKE_WR;
               end else begin
                  i_in     = i_next;
                  state_in = S_SCAN_RD;
               end
            end else if (sts.match) begin
               if (sts.hit_free) begin
                  res_in   = ST_DOUBLE_FREE;
                  grant_in = 1'b0;
                  state_in = S_RESULT;
               end else begin
                  cmd.lat_hit = 1'b1;
                  state_in    = S_NX_RD;
               end
            end else begin
               cmd.lat_prev = 1'b1;
               i_in         = i_next;
               state_in     = S_SCAN_RD;
            end
         end
         S_UP_RD: begin
            if (k_ff > i_next) begin
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = IDX_W'(k_ff - CNT_W'(1));
               state_in    = S_UP_WR;
            end else begin
               state_in = S_REM_WR;
            end
         end
         S_UP_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = k_ff[IDX_W-1:0];
            cmd.wr_sel  = WS_COPY;
            k_in        = k_ff - CNT_W'(1);
            state_in    = S_UP_RD;
         end
         S_REM_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = i_next[IDX_W-1:0];
            cmd.wr_sel  = WS_REMAIN;
            cnt_in      = cnt_ff + CNT_W'(1);
            state_in    = S_TAKE_WR;
         end
         S_TAKE_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = i_ff[IDX_W-1:0];
            cmd.wr_sel  = sp_ff ? WS_TAKE_PART : WS_TAKE_ALL;
            res_in      = ST_OK;
            grant_in    = 1'b1;
            state_in    = S_RESULT;
         end
         S_NX_RD: begin
            if (i_next < cnt_ff) begin
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = i_next[IDX_W-1:0];
               state_in    = S_NX_CHK;
            end else begin
               state_in = S_MERGE;
            end
         end
         S_NX_CHK: begin
            cmd.lat_next = 1'b1;
            state_in     = S_MERGE;
         end
         S_MERGE: begin
            cmd.wr_en = 1'b1;
            d_in      = {1'b0, left} + {1'b0, sts.right_free};
            if (left) begin
               cmd.wr_addr = IDX_W'(i_ff - CNT_W'(1));
               cmd.wr_sel  = WS_MERGE_LEFT;
               k_in        = i_ff;
            end else begin
               cmd.wr_addr = i_ff[IDX_W-1:0];
               cmd.wr_sel  = WS_MERGE_SELF;
               k_in        = i_next;
            end
            state_in = S_DN_RD;
         end
         S_DN_RD: begin
            if (k_far < cnt_ff) begin
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = k_far[IDX_W-1:0];
               state_in    = S_DN_WR;
            end else begin
               cnt_in   = cnt_ff - CNT_W'(d_ff);
               res_in   = ST_OK;
               grant_in = 1'b0;
               state_in = S_RESULT;
            end
         end
         S_DN_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = k_ff[IDX_W-1:0];
            cmd.wr_sel  = WS_COPY;
            k_in        = k_ff + CNT_W'(1);
            state_in    = S_DN_RD;
         end
         S_RESULT: begin
            if (!sts.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_INIT;
      endcase

      if (csr_wr_en) begin
         state_in = S_INIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         cnt_ff   <= CNT_W'(1);
         i_ff     <= '0;
         k_ff     <= '0;
         d_ff     <= '0;
         sp_ff    <= 1'b0;
         res_ff   <= ST_OK;
         grant_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         i_ff     <= i_in;
         k_ff     <= k_in;
         d_ff     <= d_in;
         sp_ff    <= sp_in;
         res_ff   <= res_in;
         grant_ff <= grant_in;
      end
   end

endmodule

FILE: rtl/ffha_checker.sv
// Port-level checks for the allocator, bound to the top level.
module ffha_checker import ffha_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [1:0]       rsp_status,
   input logic [OFF_W-1:0] rsp_payload_offset
);

   // response beat holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
                                 && $stable(rsp_payload_offset))
      else $error("response beat dropped or changed while stalled");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_offset_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> rsp_payload_offset == '0)
      else $error("offset nonzero on failed request");

   a_offset_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload_offset[2:0] == 3'b000)
      else $error("payload offset not 8-byte aligned");

endmodule

bind first_fit_heap_allocator_top ffha_checker u_ffha_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_status         (rsp_status),
   .rsp_payload_offset (rsp_payload_offset)
);

FILE: bench/ffha_checker.sv
// Watches the request and response channels, predicts allocator responses and compares them.
module ffha_scoreboard import ffha_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [HEAP_W-1:0] csr_wr_data,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic              req_kind,
   input  logic [OFF_W-1:0]  req_request_bytes,
   input  logic [OFF_W-1:0]  req_release_offset,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [1:0]        rsp_status,
   input  logic [OFF_W-1:0]  rsp_payload_offset,
   output int                fail_count,
   output int                pending_count,
   output int                rsp_seen
);

   typedef struct {
      status_type       status;
      logic [OFF_W-1:0] offset;
   } grant_type;

   logic [31:0] blk_start [MAX_BLOCKS];
   logic [31:0] blk_size  [MAX_BLOCKS];
   logic        blk_free  [MAX_BLOCKS];
   int          blk_count;
   grant_type   expected_q [$];

   function automatic void rebuild_table(input logic [HEAP_W-1:0] heap);
      logic [31:0] h;
      h = (heap > HEAP_LIMIT) ? HEAP_LIMIT : heap;
      for (int k = 0; k < MAX_BLOCKS; k++) begin
         blk_start[k] = 0;
         blk_size[k]  = 0;
         blk_free[k]  = 0;
      end
      blk_start[0] = CONTROL_BYTES;
      blk_size[0]  = (h >= CONTROL_BYTES + HEADER_BYTES) ? h - CONTROL_BYTES - HEADER_BYTES : 0;
      blk_free[0]  = 1;
      blk_count    = 1;
   endfunction

   function automatic void drop_entry(input int idx);
      for (int k = idx; k + 1 < blk_count; k++) begin
         blk_start[k] = blk_start[k+1];
         blk_size[k]  = blk_size[k+1];
         blk_free[k]  = blk_free[k+1];
      end
      blk_count--;
      blk_start[blk_count] = 0;
      blk_size[blk_count]  = 0;
      blk_free[blk_count]  = 0;
   endfunction

   function automatic void coalesce();
      int i;
      i = 0;
      while (i + 1 < blk_count) begin
         if (blk_free[i] && blk_free[i+1]
             && blk_start[i+1] == blk_start[i] + HEADER_BYTES + blk_size[i]) begin
            blk_size[i] += HEADER_BYTES + blk_size[i+1];
            drop_entry(i + 1);
         end else begin
            i++;
         end
      end
   endfunction

   function automatic grant_type predict_grant(input logic kind, input logic [OFF_W-1:0] req,
                                               input logic [OFF_W-1:0] off);
      grant_type   g;
      logic [31:0] need;
      logic [31:0] have;
      g.status = ST_NO_SPACE;
      g.offset = '0;
      if (kind == 1'b0) begin
         need = (32'(req) + 7) & ~32'd7;
         for (int i = 0; i < blk_count; i++) begin
            if (blk_free[i] && blk_size[i] >= need) begin
               have = blk_size[i];
               if (have >= need + HEADER_BYTES + MIN_SPLIT && blk_count < MAX_BLOCKS) begin
                  for (int k = blk_count; k > i + 1; k--) begin
                     blk_start[k] = blk_start[k-1];
                     blk_size[k]  = blk_size[k-1];
                     blk_free[k]  = blk_free[k-1];
                  end
                  blk_start[i+1] = blk_start[i] + HEADER_BYTES + need;
                  blk_size[i+1]  = have - need - HEADER_BYTES;
                  blk_free[i+1]  = 1;
                  blk_count++;
                  blk_size[i] = need;
               end
               blk_free[i] = 0;
               g.status = ST_OK;
               g.offset = OFF_W'(blk_start[i] + HEADER_BYTES);
               return g;
            end
         end
      end else begin
         g.status = ST_NOT_START;
         for (int i = 0; i < blk_count; i++) begin
            if (blk_start[i] + HEADER_BYTES == 32'(off)) begin
               if (blk_free[i]) begin
                  g.status = ST_DOUBLE_FREE;
               end else begin
                  blk_free[i] = 1;
                  coalesce();
                  g.status = ST_OK;
               end
               return g;
            end
         end
      end
      return g;
   endfunction

   always @(posedge clock) begin
      grant_type g;
      if (reset) begin
         rebuild_table(HEAP_RESET);
         expected_q.delete();
         fail_count <= 0;
         rsp_seen   <= 0;
      end else begin
         if (csr_wr_en) rebuild_table(csr_wr_data);
         if (rsp_valid && rsp_ready) begin
            rsp_seen <= rsp_seen + 1;
            if (expected_q.size() == 0) begin
               $display("%0t: response beat with nothing expected: status %0d offset %0d",
                        $time, rsp_status, rsp_payload_offset);
               fail_count <= fail_count + 1;
            end else begin
               g = expected_q.pop_front();
               if (rsp_status !== g.status || rsp_payload_offset !== g.offset) begin
                  $display("%0t: mismatch: expected status %0d offset %0d, got %0d %0d",
                           $time, g.status, g.offset, rsp_status, rsp_payload_offset);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && req_ready)
            expected_q.push_back(predict_grant(req_kind, req_request_bytes, req_release_offset));
      end
      pending_count <= expected_q.size();
   end

endmodule

FILE: bench/tb.sv
// Stimulus and verdict for the first-fit heap allocator.
module tb;
   import ffha_pkg::*;

   logic              clock = 0;
   logic              reset = 1;
   logic              csr_wr_en = 0;
   logic [HEAP_W-1:0] csr_wr_data = '0;
   logic              req_valid = 0;
   logic              req_ready;
   logic              req_kind = 0;
   logic [OFF_W-1:0]  req_request_bytes = '0;
   logic [OFF_W-1:0]  req_release_offset = '0;
   logic              rsp_valid;
   logic              rsp_ready = 0;
   logic [1:0]        rsp_status;
   logic [OFF_W-1:0]  rsp_payload_offset;
   int                fail_count, pending_count, rsp_seen;
   int                cycle_count = 0;
   int                send_idle_pct = 0;   // chance of an idle cycle before a beat
   int                stall_pct = 0;       // chance the receiver holds rsp_ready low
   logic [OFF_W-1:0]  granted_q [$];       // offsets handed out, candidates for release
   int                beats_sent = 0;

   localparam int CYCLE_LIMIT = 900000;

   always #4 clock = ~clock;

   first_fit_heap_allocator_top DUT (.*);

   ffha_scoreboard u_checker (.*);

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= stall_pct);

   // keep a list of live grants so releases mostly hit real blocks
   always @(posedge clock)
      if (!reset && rsp_valid && rsp_ready && rsp_status == ST_OK && rsp_payload_offset != 0)
         granted_q.push_back(rsp_payload_offset);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // one beat: optional idle gap, then hold valid until accepted
   task automatic send_beat(input logic kind, input logic [OFF_W-1:0] req,
                            input logic [OFF_W-1:0] off);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid          <= 1;
      req_kind           <= kind;
      req_request_bytes  <= req;
      req_release_offset <= off;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      beats_sent++;
   endtask

   // stop sending, wait for every response, then give the table walk time to settle
   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4 * MAX_BLOCKS + 16) @(posedge clock);
   endtask

   task automatic write_heap(input logic [HEAP_W-1:0] heap);
      drain();
      csr_wr_en   <= 1;
      csr_wr_data <= heap;
      @(posedge clock);
      csr_wr_en <= 0;
      granted_q.delete();
      @(posedge clock);
   endtask

   // random beat: mostly small allocs and releases of live grants, some noise
   task automatic random_beat();
      int pick;
      int idx;
      pick = $urandom_range(99);
      if (pick < 50) begin
         send_beat(0, OFF_W'(($urandom_range(3) == 0) ? $urandom_range(2000)
                                                      : $urandom_range(200)),
                   OFF_W'($urandom));
      end else if (pick < 85 && granted_q.size() > 0) begin
         idx = $urandom_range(granted_q.size() - 1);
         send_beat(1, OFF_W'($urandom), granted_q[idx]);
         granted_q.delete(idx);
      end else if (pick < 92) begin
         send_beat(0, OFF_W'($urandom), OFF_W'($urandom));
      end else begin
         send_beat(1, OFF_W'($urandom), OFF_W'($urandom));
      end
   endtask

   initial begin
      logic [OFF_W-1:0] first_off;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: reset heap, extremes, zero request, double free, bad offsets
      send_beat(0, 0, 0);
      send_beat(0, 1, 0);
      send_beat(0, 20'hFFFFF, 0);
      send_beat(1, 0, 20'd32);
      send_beat(1, 0, 20'd32);
      send_beat(1, 0, 0);
      send_beat(1, 0, 20'hFFFFF);
      send_beat(1, 0, 20'd33);
      send_beat(0, 65536 - 32, 0);
      send_beat(0, 8, 0);

      // tiny heaps: below overhead, exactly overhead, and just enough to split
      write_heap(0);
      send_beat(0, 0, 0);
      send_beat(0, 0, 0);
      write_heap(32);
      send_beat(0, 0, 0);
      write_heap(64);
      send_beat(0, 0, 0);
      send_beat(0, 0, 0);

      // oversized heap clamps to the limit; the last block ends at the top
      write_heap(21'h1FFFFF);
      send_beat(0, 1048576 - 32 - 32 - 24, 0);
      send_beat(0, 0, 0);
      write_heap(1048576);
      send_beat(0, 20'hFFFFF, 0);

      // fill the table so later allocs go out whole, with a pause until idle
      write_heap(4096);
      repeat (66) send_beat(0, 8, 0);
      drain();
      first_off = 20'd32;
      send_beat(1, 0, first_off);
      send_beat(1, 0, first_off + OFF_W'(32));
      send_beat(1, 0, first_off + OFF_W'(64));
      send_beat(0, 0, 0);

      // random phases over several heap sizes and idling mixes
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  write_heap(2048); end
            1: begin send_idle_pct = 59; stall_pct = 0;  write_heap(65536); end
            2: begin send_idle_pct = 0;  stall_pct = 59; write_heap(1024); end
            default: begin send_idle_pct = 31; stall_pct = 31; write_heap(8192); end
         endcase
         repeat (115) random_beat();
      end

      send_idle_pct = 0;
      stall_pct = 0;
      drain();
      $display("tb: %0d request beats, %0d response beats, heaps from 0 to clamp",
               beats_sent, rsp_seen);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
